// File: design/gptp_pkg.sv
// Shared types and constants for the GPT partition table parser.
package gptp_pkg;

	localparam int SECTOR_BYTES_DEF = 512;
	localparam int MAX_ENTRIES_DEF  = 128;
	localparam int NAME_CAP_DEF     = 32;
	localparam int QUEUE_DEPTH_DEF  = 4;

	localparam int MIN_HEADER = 92;
	localparam int MIN_ENTRY  = 128;

	localparam logic [7:0] SIG_BYTES [8] = '{
		8'h45, 8'h46, 8'h49, 8'h20, 8'h50, 8'h41, 8'h52, 8'h54
	};

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_NAME   = 2'd1,
		KIND_RECORD = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	// Everything one input byte produces: up to three results.
	typedef struct packed {
		logic        has_hdr;
		logic        has_name;
		logic        has_rec;
		logic        has_done;
		logic        hdr_ok;
		logic [63:0] table_lba;
		logic [7:0]  entry_count;
		logic [31:0] entry_bytes;
		logic [6:0]  name_char;
		logic [6:0]  part_index;
		logic [63:0] part_start;
		logic [63:0] part_end;
		logic [31:0] part_sectors;
		logic [7:0]  found;
	} bundle_t;

	typedef struct packed {
		kind_t       kind;
		logic        header_valid;
		logic [63:0] table_lba;
		logic [7:0]  entry_count;
		logic [31:0] entry_bytes;
		logic [6:0]  partition_index;
		logic [63:0] part_start;
		logic [63:0] part_end;
		logic [31:0] part_sectors;
		logic [6:0]  name_char;
		logic [7:0]  found_count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: design/gpt_partition_table_parser_top.sv
// Top level of the GPT partition table parser.
// The parser takes one stream byte per cycle while byte_stall is low: a header sector,
// then the entry array. A byte that yields one to three results pushes a bundle into
// a four-deep queue; the output drain hands out one result per cycle while result_stall
// is low. A byte that yields two or three results (header end, last byte of an entry)
// holds the queue head until all are drained; byte_stall rises only when the queue is
// full, so the input runs at one byte per cycle whenever result_stall stays low.
// part_limit is written through the cfg channel, which is always ready; write it only
// while the block is idle.
module gpt_partition_table_parser_top #(
	parameter int SECTOR_BYTES = gptp_pkg::SECTOR_BYTES_DEF,
	parameter int MAX_ENTRIES  = gptp_pkg::MAX_ENTRIES_DEF,
	parameter int NAME_CAP     = gptp_pkg::NAME_CAP_DEF,
	parameter int QUEUE_DEPTH  = gptp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  part_limit,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_of_header,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic        header_valid,
	output logic [63:0] table_lba,
	output logic [7:0]  entry_count,
	output logic [31:0] entry_bytes,
	output logic [6:0]  partition_index,
	output logic [63:0] part_start,
	output logic [63:0] part_end,
	output logic [31:0] part_sectors,
	output logic [6:0]  name_char,
	output logic [7:0]  found_count,
	output logic        last
);

	logic                cfg_write;
	logic [7:0]          limit_q;
	logic                take, push, pop;
	gptp_pkg::bundle_t   bundle, head;
	gptp_pkg::q_status_t qstat;
	gptp_pkg::result_t   res_q;

	assign cfg_ready  = 1'b1;
	assign byte_stall = qstat.full;
	assign take       = byte_valid && !byte_stall;
	assign cfg_write  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= 8'd128;
		else if (cfg_write)
			limit_q <= part_limit;
	end

	gptp_front #(
		.SECTOR_BYTES (SECTOR_BYTES),
		.MAX_ENTRIES  (MAX_ENTRIES),
		.NAME_CAP     (NAME_CAP)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.data_byte       (data_byte),
		.start_of_header (start_of_header),
		.part_limit      (limit_q),
		.push            (push),
		.bundle          (bundle)
	);

	gptp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (bundle),
		.pop    (pop),
		.dout   (head),
		.status (qstat)
	);

	gptp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.res_q        (res_q)
	);

	assign kind            = res_q.kind;
	assign header_valid    = res_q.header_valid;
	assign table_lba       = res_q.table_lba;
	assign entry_count     = res_q.entry_count;
	assign entry_bytes     = res_q.entry_bytes;
	assign partition_index = res_q.partition_index;
	assign part_start      = res_q.part_start;
	assign part_end        = res_q.part_end;
	assign part_sectors    = res_q.part_sectors;
	assign name_char       = res_q.name_char;
	assign found_count     = res_q.found_count;
	assign last            = res_q.last;

endmodule

// File: design/gptp_front.sv
// Byte parser: walks header and entry array, builds one result bundle per byte.
module gptp_front #(
	parameter int SECTOR_BYTES = gptp_pkg::SECTOR_BYTES_DEF,
	parameter int MAX_ENTRIES  = gptp_pkg::MAX_ENTRIES_DEF,
	parameter int NAME_CAP     = gptp_pkg::NAME_CAP_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic                start_of_header,
	input  logic [7:0]          part_limit,
	output logic                push,
	output gptp_pkg::bundle_t   bundle
);

	localparam int HOFF_W = $clog2(SECTOR_BYTES);
	localparam int NL_W   = $clog2(NAME_CAP);

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_TABLE  = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	phase_t            phase_q, phase_n, ph;
	logic [HOFF_W-1:0] hoff_q, hoff_n, ho;
	logic              sig_ok_q, sig_ok_n, so;
	logic [31:0]       hdr_len_q, hdr_len_n;
	logic [63:0]       arr_lba_q, arr_lba_n;
	logic [31:0]       left_q, left_n;
	logic [31:0]       ent_len_q, ent_len_n;
	logic [31:0]       eoff_q, eoff_n;
	logic [7:0]        num_q, num_n;
	logic [7:0]        rep_q, rep_n;
	logic              tn_q, tn_n;
	logic [63:0]       start_q, start_n;
	logic [63:0]       end_q, end_n;
	logic [NL_W-1:0]   nlen_q, nlen_n;
	logic              nend_q, nend_n;
	logic [7:0]        low_q, low_n;
	logic              ok;
	logic [31:0]       capped;
	logic [8:0]        rep_sum;
	logic [31:0]       span;

	always_comb begin
		phase_n   = phase_q;
		hoff_n    = hoff_q;
		sig_ok_n  = sig_ok_q;
		hdr_len_n = hdr_len_q;
		arr_lba_n = arr_lba_q;
		left_n    = left_q;
		ent_len_n = ent_len_q;
		eoff_n    = eoff_q;
		num_n     = num_q;
		rep_n     = rep_q;
		tn_n      = tn_q;
		start_n   = start_q;
		end_n     = end_q;
		nlen_n    = nlen_q;
		nend_n    = nend_q;
		low_n     = low_q;
		bundle    = '0;
		ok        = 1'b0;
		capped    = left_q;
		rep_sum   = {1'b0, rep_q} + 9'(tn_q);
		span      = end_q[31:0] - start_q[31:0] + 32'd1;
		ph        = start_of_header ? PH_HEADER : phase_q;
		ho        = start_of_header ? '0 : hoff_q;
		so        = start_of_header ? 1'b1 : sig_ok_q;

		if (take && ph == PH_HEADER) begin
			phase_n  = PH_HEADER;
			hoff_n   = ho + HOFF_W'(1);
			sig_ok_n = so;
			if (ho < HOFF_W'(8) && data_byte != gptp_pkg::SIG_BYTES[ho[2:0]])
				sig_ok_n = 1'b0;
			if (ho >= HOFF_W'(12) && ho < HOFF_W'(16))
				hdr_len_n[8*ho[1:0] +: 8] = data_byte;
			if (ho >= HOFF_W'(72) && ho < HOFF_W'(80))
				arr_lba_n[8*ho[2:0] +: 8] = data_byte;
			if (ho >= HOFF_W'(80) && ho < HOFF_W'(84))
				left_n[8*ho[1:0] +: 8] = data_byte;
			if (ho >= HOFF_W'(84) && ho < HOFF_W'(88))
				ent_len_n[8*ho[1:0] +: 8] = data_byte;
			if (ho == HOFF_W'(SECTOR_BYTES - 1)) begin
				hoff_n = ho;
				ok = so && hdr_len_q >= 32'(gptp_pkg::MIN_HEADER)
					&& ent_len_q >= 32'(gptp_pkg::MIN_ENTRY) && left_q != 32'd0;
				capped = (left_q > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : left_q;
				bundle.has_hdr     = 1'b1;
				bundle.hdr_ok      = ok;
				bundle.table_lba   = arr_lba_q;
				bundle.entry_count = ok ? capped[7:0] : 8'd0;
				bundle.entry_bytes = ent_len_q;
				left_n = capped;
				num_n  = '0;
				rep_n  = '0;
				eoff_n = '0;
				tn_n   = 1'b0;
				nlen_n = '0;
				nend_n = 1'b0;
				if (!ok || part_limit == 8'd0) begin
					bundle.has_done = 1'b1;
					phase_n = PH_DONE;
				end else begin
					phase_n = PH_TABLE;
				end
			end
		end else if (take && ph == PH_TABLE) begin
			if (eoff_q < 32'd16) begin
				if (data_byte != 8'd0)
					tn_n = 1'b1;
			end else if (eoff_q[31:3] == 29'd4) begin
				start_n[8*eoff_q[2:0] +: 8] = data_byte;
			end else if (eoff_q[31:3] == 29'd5) begin
				end_n[8*eoff_q[2:0] +: 8] = data_byte;
			end else if (eoff_q >= 32'd56 && eoff_q < 32'd128) begin
				if (!eoff_q[0]) begin
					low_n = data_byte;
				end else if (tn_q && !nend_q) begin
					if (data_byte == 8'd0 && low_q == 8'd0) begin
						nend_n = 1'b1;
					end else if (data_byte == 8'd0 && !low_q[7]
						&& nlen_q < NL_W'(NAME_CAP - 1)) begin
						bundle.has_name  = 1'b1;
						bundle.name_char = low_q[6:0];
						nlen_n = nlen_q + NL_W'(1);
					end
				end
			end

			if (eoff_q == ent_len_q - 32'd1) begin
				if (tn_q) begin
					bundle.has_rec      = 1'b1;
					bundle.part_index   = num_q[6:0];
					bundle.part_start   = start_q;
					bundle.part_end     = end_q;
					bundle.part_sectors = span;
				end
				rep_n  = rep_sum[7:0];
				num_n  = num_q + 8'd1;
				left_n = left_q - 32'd1;
				eoff_n = '0;
				tn_n   = 1'b0;
				nlen_n = '0;
				nend_n = 1'b0;
				if (left_q == 32'd1 || rep_sum >= {1'b0, part_limit}) begin
					bundle.has_done = 1'b1;
					bundle.found    = rep_sum[7:0];
					phase_n = PH_DONE;
				end
			end else begin
				eoff_n = eoff_q + 32'd1;
			end
		end
	end

	assign push = take && (bundle.has_hdr || bundle.has_name
		|| bundle.has_rec || bundle.has_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			hoff_q   <= '0;
			sig_ok_q <= 1'b1;
			eoff_q   <= '0;
			num_q    <= '0;
			rep_q    <= '0;
			tn_q     <= 1'b0;
			nlen_q   <= '0;
			nend_q   <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			hoff_q   <= hoff_n;
			sig_ok_q <= sig_ok_n;
			eoff_q   <= eoff_n;
			num_q    <= num_n;
			rep_q    <= rep_n;
			tn_q     <= tn_n;
			nlen_q   <= nlen_n;
			nend_q   <= nend_n;
		end
	end

	// header and entry fields: every byte is rewritten before it is read
	always_ff @(posedge clk) begin
		hdr_len_q <= hdr_len_n;
		arr_lba_q <= arr_lba_n;
		left_q    <= left_n;
		ent_len_q <= ent_len_n;
		start_q   <= start_n;
		end_q     <= end_n;
		low_q     <= low_n;
	end

	a_hdr_rec_apart: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !(bundle.has_hdr && bundle.has_rec))
		else $error("header and record in one bundle");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(push && bundle.has_done) |=> phase_q == PH_DONE)
		else $error("done result without done phase");

endmodule

// File: design/gptp_queue.sv
// Short bundle queue between the parser and the result drain.
module gptp_queue #(
	parameter int DEPTH = gptp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  gptp_pkg::bundle_t    din,
	input  logic                 pop,
	output gptp_pkg::bundle_t    dout,
	output gptp_pkg::q_status_t  status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	gptp_pkg::bundle_t slot_q [DEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [CW-1:0]     cnt_q;

	assign dout         = slot_q[rd_q];
	assign status.full  = (cnt_q == CW'(DEPTH));
	assign status.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from empty queue");

endmodule

// File: design/gptp_back.sv
// Result drain: splits each queued bundle into single results on the output register.
module gptp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gptp_pkg::bundle_t    head,
	input  gptp_pkg::q_status_t  qstat,
	output logic                 pop,
	input  logic                 result_stall,
	output logic                 result_valid,
	output gptp_pkg::result_t    res_q
);

	logic [3:0]        sent_q;
	logic [3:0]        pending, pick;
	logic              load, is_last;
	gptp_pkg::result_t res;

	assign load    = !result_valid || !result_stall;
	assign pending = {head.has_done, head.has_rec, head.has_name, head.has_hdr} & ~sent_q;

	always_comb begin
		pick = 4'b0000;
		res  = '0;
		priority if (pending[0]) begin
			pick = 4'b0001;
			res.kind         = gptp_pkg::KIND_HEADER;
			res.header_valid = head.hdr_ok;
			res.table_lba    = head.table_lba;
			res.entry_count  = head.entry_count;
			res.entry_bytes  = head.entry_bytes;
		end else if (pending[1]) begin
			pick = 4'b0010;
			res.kind      = gptp_pkg::KIND_NAME;
			res.name_char = head.name_char;
		end else if (pending[2]) begin
			pick = 4'b0100;
			res.kind            = gptp_pkg::KIND_RECORD;
			res.partition_index = head.part_index;
			res.part_start      = head.part_start;
			res.part_end        = head.part_end;
			res.part_sectors    = head.part_sectors;
		end else begin
			pick = 4'b1000;
			res.kind        = gptp_pkg::KIND_DONE;
			res.found_count = head.found;
		end
		is_last  = ((pending & ~pick) == 4'b0000);
		res.last = is_last;
	end

	assign pop = load && !qstat.empty && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			sent_q       <= 4'b0000;
		end else if (load) begin
			result_valid <= !qstat.empty;
			if (!qstat.empty)
				sent_q <= is_last ? 4'b0000 : (sent_q | pick);
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

endmodule
